// File: sv/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg
// shared codes, reset values, result bundle and header checksum helpers for
// the stop-and-wait arq sender
// ----------------------------------------------------------------------------
package sawarq_pkg;

    // command codes
    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    // action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_XMIT    = 3'd1;
    localparam logic [2:0] ACT_SEG_ACK = 3'd2;
    localparam logic [2:0] ACT_END_ACK = 3'd3;
    localparam logic [2:0] ACT_FAIL    = 3'd4;

    // transfer phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;

    localparam logic [7:0] TAG_DATA = 8'h00;
    localparam logic [7:0] TAG_END  = 8'h08;

    // register index, taken from paddr[2]
    localparam logic REG_INIT_TIMEOUT = 1'b0;
    localparam logic REG_RETRY_LIMIT  = 1'b1;

    localparam logic [15:0] INIT_TIMEOUT_RST = 16'd1000;
    localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd10;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx_tag;
        logic [7:0]  tx_seq;
        logic [7:0]  tx_ack;
        logic [7:0]  tx_window;
        logic [15:0] tx_length;
        logic [15:0] tx_checksum;
        logic [7:0]  retry_number;
    } result_t;

    // 16-bit add with end-around carry
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        begin
            t = {1'b0, a} + {1'b0, b};
            return t[15:0] + {15'd0, t[16]};
        end
    endfunction

    // inverted ones' complement sum of four words
    function automatic logic [15:0] ones_sum(input logic [15:0] w0, input logic [15:0] w1,
                                             input logic [15:0] w2, input logic [15:0] w3);
        logic [15:0] s;
        begin
            s = fold_add(fold_add(fold_add(w0, w1), w2), w3);
            return ~s;
        end
    endfunction

    function automatic result_t make_header(input logic [7:0] tag, input logic [7:0] seq,
                                            input logic [7:0] ack, input logic [7:0] win,
                                            input logic [15:0] len, input logic [7:0] retries);
        result_t r;
        begin
            r.action       = ACT_XMIT;
            r.tx_tag       = tag;
            r.tx_seq       = seq;
            r.tx_ack       = ack;
            r.tx_window    = win;
            r.tx_length    = len;
            r.tx_checksum  = ones_sum(len, {win, tag}, {ack, seq}, 16'd0);
            r.retry_number = retries;
            return r;
        end
    endfunction

    function automatic result_t empty_result(input logic [2:0] act);
        result_t r;
        begin
            r        = '0;
            r.action = act;
            return r;
        end
    endfunction

endpackage

// File: sv/stop_and_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// header side of a stop-and-wait arq sender: builds data and end headers,
// runs the retransmit timer with backoff and checks reply headers
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        in_valid, in_stall, command .. reply_*    beat in, one per item
//  out       out_valid, out_stall, action .. retry_*   beat out, one per item
//  cfg       psel, penable, pwrite, paddr, pwdata ...  register access
//
//  every input beat gives exactly one output beat, through the input register
//  and then the result register; a new beat is taken every cycle while the
//  output is not stalled
//  all protocol state sits in flip-flops cleared by rst_n, no clearing pass
//  out_stall holds the result register, and the input register behind it
//  fills before in_stall rises
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] seg_length,
    input  logic [15:0] reply_word0,
    input  logic [15:0] reply_word1,
    input  logic [15:0] reply_word2,
    input  logic [15:0] reply_word3,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [7:0]  tx_tag,
    output logic [7:0]  tx_seq,
    output logic [7:0]  tx_ack,
    output logic [7:0]  tx_window,
    output logic [15:0] tx_length,
    output logic [15:0] tx_checksum,
    output logic [7:0]  retry_number,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [15:0] init_timeout_reg;
    logic [7:0]  retry_limit_reg;

    // input stage
    logic        v1_reg;
    logic [1:0]  cmd1_reg;
    logic [15:0] len1_reg;
    logic [15:0] w0_reg, w1_reg, w2_reg, w3_reg;

    // protocol state
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  seq_reg, seq_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [31:0] timeout_reg, timeout_next;
    logic [7:0]  retries_reg, retries_next;
    logic [15:0] hlen_reg, hlen_next;
    logic [7:0]  hseq_reg, hseq_next;
    logic [7:0]  hack_reg, hack_next;
    logic [7:0]  hwin_reg, hwin_next;
    logic [7:0]  htag_reg, htag_next;
    logic [15:0] segkept_reg, segkept_next;

    // result register
    logic                 out_valid_reg;
    sawarq_pkg::result_t  res_reg, res_next;

    logic        advance;
    logic        in_accept;
    logic        cfg_write;
    logic [31:0] elapsed_inc;
    logic [31:0] timeout_dbl;
    logic [7:0]  seq_plus1;
    logic        reply_good;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    assign advance   = v1_reg & ~(out_valid_reg & out_stall);
    assign in_stall  = v1_reg & ~advance;
    assign in_accept = in_valid & ~in_stall;

    always_comb
    begin
        case (paddr[2])
            sawarq_pkg::REG_INIT_TIMEOUT: prdata = {16'd0, init_timeout_reg};
            sawarq_pkg::REG_RETRY_LIMIT:  prdata = {24'd0, retry_limit_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_timeout_reg <= sawarq_pkg::INIT_TIMEOUT_RST;
            retry_limit_reg  <= sawarq_pkg::RETRY_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == sawarq_pkg::REG_INIT_TIMEOUT)
                init_timeout_reg <= pwdata[15:0];
            else
                retry_limit_reg <= pwdata[7:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (in_accept)
            v1_reg <= 1'b1;
        else if (advance)
            v1_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd1_reg <= command;
            len1_reg <= seg_length;
            w0_reg   <= reply_word0;
            w1_reg   <= reply_word1;
            w2_reg   <= reply_word2;
            w3_reg   <= reply_word3;
        end
    end

    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 32'd1;
    assign timeout_dbl = timeout_reg[31] ? 32'hffff_ffff : {timeout_reg[30:0], 1'b0};
    assign seq_plus1   = seq_reg + 8'd1;
    assign reply_good  = (sawarq_pkg::ones_sum(w0_reg, w1_reg, w2_reg, w3_reg) == 16'd0);

    always_comb
    begin
        phase_next   = phase_reg;
        seq_next     = seq_reg;
        elapsed_next = elapsed_reg;
        timeout_next = timeout_reg;
        retries_next = retries_reg;
        hlen_next    = hlen_reg;
        hseq_next    = hseq_reg;
        hack_next    = hack_reg;
        hwin_next    = hwin_reg;
        htag_next    = htag_reg;
        segkept_next = segkept_reg;
        res_next     = sawarq_pkg::empty_result(sawarq_pkg::ACT_NONE);

        case (cmd1_reg)
            sawarq_pkg::CMD_SEND:
            begin
                if (phase_reg == sawarq_pkg::PH_IDLE)
                begin
                    segkept_next = len1_reg;
                    htag_next    = sawarq_pkg::TAG_DATA;
                    hseq_next    = seq_reg;
                    hlen_next    = len1_reg;
                    elapsed_next = 32'd0;
                    timeout_next = {16'd0, init_timeout_reg};
                    retries_next = 8'd0;
                    phase_next   = sawarq_pkg::PH_DATA;
                    res_next     = sawarq_pkg::make_header(sawarq_pkg::TAG_DATA, seq_reg,
                                                           hack_reg, hwin_reg, len1_reg, 8'd0);
                end
            end
            sawarq_pkg::CMD_END:
            begin
                if (phase_reg == sawarq_pkg::PH_IDLE)
                begin
                    htag_next    = sawarq_pkg::TAG_END;
                    elapsed_next = 32'd0;
                    timeout_next = {16'd0, init_timeout_reg};
                    retries_next = 8'd0;
                    phase_next   = sawarq_pkg::PH_END;
                    res_next     = sawarq_pkg::make_header(sawarq_pkg::TAG_END, hseq_reg,
                                                           hack_reg, hwin_reg, hlen_reg, 8'd0);
                end
            end
            sawarq_pkg::CMD_TICK:
            begin
                if (phase_reg != sawarq_pkg::PH_IDLE)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > timeout_reg)
                    begin
                        if (retries_reg >= retry_limit_reg)
                        begin
                            phase_next = sawarq_pkg::PH_IDLE;
                            seq_next   = 8'd0;
                            res_next   = sawarq_pkg::empty_result(sawarq_pkg::ACT_FAIL);
                        end
                        else
                        begin
                            // end phase restarts its timer, data phase keeps counting
                            if (phase_reg == sawarq_pkg::PH_END)
                                elapsed_next = 32'd0;
                            timeout_next = timeout_dbl;
                            retries_next = retries_reg + 8'd1;
                            res_next     = sawarq_pkg::make_header(htag_reg, hseq_reg,
                                                                   hack_reg, hwin_reg,
                                                                   hlen_reg,
                                                                   retries_reg + 8'd1);
                        end
                    end
                end
            end
            default:
            begin
                if (phase_reg != sawarq_pkg::PH_IDLE)
                begin
                    // the reply header overwrites the whole header image
                    hlen_next = w0_reg;
                    htag_next = w1_reg[7:0];
                    hwin_next = w1_reg[15:8];
                    hseq_next = w2_reg[7:0];
                    hack_next = w2_reg[15:8];
                    if (phase_reg == sawarq_pkg::PH_DATA)
                    begin
                        if (reply_good && (w2_reg[15:8] == seq_plus1))
                        begin
                            seq_next   = seq_plus1;
                            phase_next = sawarq_pkg::PH_IDLE;
                            res_next   = sawarq_pkg::empty_result(sawarq_pkg::ACT_SEG_ACK);
                        end
                        else if (!reply_good || (w2_reg[15:8] == seq_reg))
                        begin
                            htag_next    = sawarq_pkg::TAG_DATA;
                            hseq_next    = seq_reg;
                            hlen_next    = segkept_reg;
                            elapsed_next = 32'd0;
                            timeout_next = {16'd0, init_timeout_reg};
                            retries_next = 8'd0;
                            res_next     = sawarq_pkg::make_header(sawarq_pkg::TAG_DATA,
                                                                   seq_reg, w2_reg[15:8],
                                                                   w1_reg[15:8], segkept_reg,
                                                                   8'd0);
                        end
                        else
                        begin
                            phase_next = sawarq_pkg::PH_IDLE;
                            seq_next   = 8'd0;
                            res_next   = sawarq_pkg::empty_result(sawarq_pkg::ACT_FAIL);
                        end
                    end
                    else
                    begin
                        phase_next = sawarq_pkg::PH_IDLE;
                        seq_next   = 8'd0;
                        if (reply_good && (w1_reg[7:0] == sawarq_pkg::TAG_END))
                            res_next = sawarq_pkg::empty_result(sawarq_pkg::ACT_END_ACK);
                        else
                            res_next = sawarq_pkg::empty_result(sawarq_pkg::ACT_FAIL);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sawarq_pkg::PH_IDLE;
            seq_reg     <= 8'd0;
            elapsed_reg <= 32'd0;
            timeout_reg <= 32'd0;
            retries_reg <= 8'd0;
            hlen_reg    <= 16'd0;
            hseq_reg    <= 8'd0;
            hack_reg    <= 8'd0;
            hwin_reg    <= 8'd0;
            htag_reg    <= 8'd0;
            segkept_reg <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            elapsed_reg <= elapsed_next;
            timeout_reg <= timeout_next;
            retries_reg <= retries_next;
            hlen_reg    <= hlen_next;
            hseq_reg    <= hseq_next;
            hack_reg    <= hack_next;
            hwin_reg    <= hwin_next;
            htag_reg    <= htag_next;
            segkept_reg <= segkept_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign action       = res_reg.action;
    assign tx_tag       = res_reg.tx_tag;
    assign tx_seq       = res_reg.tx_seq;
    assign tx_ack       = res_reg.tx_ack;
    assign tx_window    = res_reg.tx_window;
    assign tx_length    = res_reg.tx_length;
    assign tx_checksum  = res_reg.tx_checksum;
    assign retry_number = res_reg.retry_number;

    // a segment ack moves the sequence on by one
    a_seq_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_next.action == sawarq_pkg::ACT_SEG_ACK))
        |=> (seq_reg == $past(seq_reg) + 8'd1) && (phase_reg == sawarq_pkg::PH_IDLE))
        else $error("segment ack did not advance the sequence");

    // failure and end ack close the transfer
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ((res_next.action == sawarq_pkg::ACT_FAIL) ||
                     (res_next.action == sawarq_pkg::ACT_END_ACK)))
        |=> (phase_reg == sawarq_pkg::PH_IDLE) && (seq_reg == 8'd0))
        else $error("transfer not closed after failure or end ack");

    // only transmit results carry header fields
    a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.action != sawarq_pkg::ACT_XMIT))
        |-> (res_reg.tx_tag == 8'd0) && (res_reg.tx_length == 16'd0) &&
            (res_reg.tx_checksum == 16'd0) && (res_reg.retry_number == 8'd0))
        else $error("non-transmit result carries header fields");

    // an idle block never transmits on a tick
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd1_reg == sawarq_pkg::CMD_TICK) && (phase_reg == sawarq_pkg::PH_IDLE))
        |-> (res_next.action == sawarq_pkg::ACT_NONE))
        else $error("tick acted while idle");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives command beats into the stop-and-wait arq sender and checks every
// result beat against a cycle-free model of the header, timer and reply logic;
// directed cases first, then long runs of random transfers under several
// timeout and retry settings with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PRINT_LIMIT = 200;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] len;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } item_t;

    typedef enum int {
        RK_ACK_NEXT,
        RK_ACK_SAME,
        RK_BAD_SUM,
        RK_ACK_OTHER,
        RK_END_OK,
        RK_END_BAD_TAG,
        RK_JUNK
    } reply_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = sawarq_pkg::CMD_TICK;
    logic [15:0] seg_length = 16'h0;
    logic [15:0] reply_word0 = 16'h0;
    logic [15:0] reply_word1 = 16'h0;
    logic [15:0] reply_word2 = 16'h0;
    logic [15:0] reply_word3 = 16'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  action;
    logic [7:0]  tx_tag;
    logic [7:0]  tx_seq;
    logic [7:0]  tx_ack;
    logic [7:0]  tx_window;
    logic [15:0] tx_length;
    logic [15:0] tx_checksum;
    logic [7:0]  retry_number;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // sender model state
    logic [15:0] cfg_timeout = sawarq_pkg::INIT_TIMEOUT_RST;
    logic [7:0]  cfg_limit = sawarq_pkg::RETRY_LIMIT_RST;
    logic [1:0]  m_phase = sawarq_pkg::PH_IDLE;
    logic [7:0]  m_seq = 8'h0;
    logic [31:0] m_elapsed = 32'h0;
    logic [31:0] m_timeout = 32'h0;
    logic [7:0]  m_retries = 8'h0;
    logic [15:0] m_hlen = 16'h0;
    logic [7:0]  m_hseq = 8'h0;
    logic [7:0]  m_hack = 8'h0;
    logic [7:0]  m_hwin = 8'h0;
    logic [7:0]  m_htag = 8'h0;
    logic [15:0] m_seg = 16'h0;

    sawarq_pkg::result_t pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    int unsigned hold_req = 0;
    bit          hold_taken = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    stop_and_wait_arq_sender dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .seg_length   (seg_length),
        .reply_word0  (reply_word0),
        .reply_word1  (reply_word1),
        .reply_word2  (reply_word2),
        .reply_word3  (reply_word3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .tx_tag       (tx_tag),
        .tx_seq       (tx_seq),
        .tx_ack       (tx_ack),
        .tx_window    (tx_window),
        .tx_length    (tx_length),
        .tx_checksum  (tx_checksum),
        .retry_number (retry_number),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    // inverted end-around-carry sum of four header words
    function automatic logic [15:0] hdr_sum(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c, input logic [15:0] d);
        logic [17:0] t;
        t = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
        t = {2'b0, t[15:0]} + {16'b0, t[17:16]};
        t = {2'b0, t[15:0]} + {17'b0, t[16]};
        return ~t[15:0];
    endfunction

    function automatic sawarq_pkg::result_t header_beat();
        sawarq_pkg::result_t r;
        r.action       = sawarq_pkg::ACT_XMIT;
        r.tx_tag       = m_htag;
        r.tx_seq       = m_hseq;
        r.tx_ack       = m_hack;
        r.tx_window    = m_hwin;
        r.tx_length    = m_hlen;
        r.tx_checksum  = hdr_sum(m_hlen, {m_hwin, m_htag}, {m_hack, m_hseq}, 16'h0);
        r.retry_number = m_retries;
        return r;
    endfunction

    function automatic void restart_timer();
        m_elapsed = 32'h0;
        m_timeout = {16'h0, cfg_timeout};
        m_retries = 8'h0;
    endfunction

    function automatic void end_transfer();
        m_phase = sawarq_pkg::PH_IDLE;
        m_seq   = 8'h0;
    endfunction

    // advances the model by one accepted beat and returns the result it gives
    function automatic sawarq_pkg::result_t arq_predict(input item_t it);
        sawarq_pkg::result_t r;
        logic       good;
        logic [7:0] rtag;
        logic [7:0] rack;
        logic [7:0] nxt;
        r        = '0;
        r.action = sawarq_pkg::ACT_NONE;
        case (it.cmd)
            sawarq_pkg::CMD_SEND:
                if (m_phase == sawarq_pkg::PH_IDLE)
                begin
                    m_seg   = it.len;
                    m_htag  = sawarq_pkg::TAG_DATA;
                    m_hseq  = m_seq;
                    m_hlen  = it.len;
                    restart_timer();
                    m_phase = sawarq_pkg::PH_DATA;
                    r       = header_beat();
                end
            sawarq_pkg::CMD_END:
                if (m_phase == sawarq_pkg::PH_IDLE)
                begin
                    m_htag  = sawarq_pkg::TAG_END;
                    restart_timer();
                    m_phase = sawarq_pkg::PH_END;
                    r       = header_beat();
                end
            sawarq_pkg::CMD_TICK:
                if (m_phase != sawarq_pkg::PH_IDLE)
                begin
                    if (m_elapsed != 32'hffff_ffff)
                        m_elapsed = m_elapsed + 32'd1;
                    if (m_elapsed > m_timeout)
                    begin
                        if (m_retries >= cfg_limit)
                        begin
                            end_transfer();
                            r.action = sawarq_pkg::ACT_FAIL;
                        end
                        else
                        begin
                            // only the end phase restarts the count on a resend
                            if (m_phase == sawarq_pkg::PH_END)
                                m_elapsed = 32'h0;
                            m_timeout = m_timeout[31] ? 32'hffff_ffff : {m_timeout[30:0], 1'b0};
                            m_retries = m_retries + 8'd1;
                            r         = header_beat();
                        end
                    end
                end
            default:
                if (m_phase != sawarq_pkg::PH_IDLE)
                begin
                    good   = (hdr_sum(it.w0, it.w1, it.w2, it.w3) == 16'h0);
                    rtag   = it.w1[7:0];
                    rack   = it.w2[15:8];
                    nxt    = m_seq + 8'd1;
                    m_hlen = it.w0;
                    m_htag = rtag;
                    m_hwin = it.w1[15:8];
                    m_hseq = it.w2[7:0];
                    m_hack = rack;
                    if (m_phase == sawarq_pkg::PH_DATA)
                    begin
                        if (good && rack == nxt)
                        begin
                            m_seq    = nxt;
                            m_phase  = sawarq_pkg::PH_IDLE;
                            r.action = sawarq_pkg::ACT_SEG_ACK;
                        end
                        else if (!good || rack == m_seq)
                        begin
                            // ack and window bytes stay as the reply left them
                            m_htag = sawarq_pkg::TAG_DATA;
                            m_hseq = m_seq;
                            m_hlen = m_seg;
                            restart_timer();
                            r = header_beat();
                        end
                        else
                        begin
                            end_transfer();
                            r.action = sawarq_pkg::ACT_FAIL;
                        end
                    end
                    else
                    begin
                        end_transfer();
                        r.action = (good && rtag == sawarq_pkg::TAG_END) ?
                                   sawarq_pkg::ACT_END_ACK : sawarq_pkg::ACT_FAIL;
                    end
                end
        endcase
        return r;
    endfunction

    function automatic item_t plain_item(input logic [1:0] cmd);
        item_t it;
        it.cmd = cmd;
        case ($urandom_range(0, 9))
            0: it.len = 16'h0000;
            1: it.len = 16'hffff;
            default: it.len = 16'($urandom);
        endcase
        it.w0 = 16'($urandom);
        it.w1 = 16'($urandom);
        it.w2 = 16'($urandom);
        it.w3 = 16'($urandom);
        return it;
    endfunction

    // reply header shaped against the current model state
    function automatic item_t make_reply(input reply_kind_t kind);
        item_t      it;
        logic [7:0] tag;
        logic [7:0] ack;
        logic [7:0] win;
        logic [7:0] rseq;
        logic [7:0] nxt;
        it     = plain_item(sawarq_pkg::CMD_REPLY);
        tag    = 8'($urandom);
        ack    = 8'($urandom);
        win    = 8'($urandom);
        rseq   = 8'($urandom);
        nxt    = m_seq + 8'd1;
        case (kind)
            RK_ACK_NEXT: ack = nxt;
            RK_ACK_SAME: ack = m_seq;
            RK_ACK_OTHER:
                while (ack == m_seq || ack == nxt)
                    ack = 8'($urandom);
            RK_END_OK: tag = sawarq_pkg::TAG_END;
            RK_END_BAD_TAG:
                while (tag == sawarq_pkg::TAG_END)
                    tag = 8'($urandom);
            RK_BAD_SUM:
            begin
                // ack may or may not match, but the checksum is always wrong
                if ($urandom_range(0, 1))
                    ack = nxt;
                if (m_phase == sawarq_pkg::PH_END)
                    tag = sawarq_pkg::TAG_END;
            end
            default: ;
        endcase
        it.w1 = {win, tag};
        it.w2 = {ack, rseq};
        if (kind == RK_JUNK)
            it.w3 = 16'($urandom);
        else if (kind == RK_BAD_SUM)
        begin
            it.w3 = 16'($urandom);
            while (hdr_sum(it.w0, it.w1, it.w2, it.w3) == 16'h0)
                it.w3 = 16'($urandom);
        end
        else
            it.w3 = hdr_sum(it.w0, it.w1, it.w2, 16'h0);
        return it;
    endfunction

    // mostly well-formed transfers, with some busy commands and junk replies
    function automatic item_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (m_phase == sawarq_pkg::PH_IDLE)
        begin
            if (r < 65) return plain_item(sawarq_pkg::CMD_SEND);
            if (r < 85) return plain_item(sawarq_pkg::CMD_END);
            if (r < 93) return plain_item(sawarq_pkg::CMD_TICK);
            return make_reply(RK_JUNK);
        end
        if (m_phase == sawarq_pkg::PH_DATA)
        begin
            if (r < 45) return plain_item(sawarq_pkg::CMD_TICK);
            if (r < 68) return make_reply(RK_ACK_NEXT);
            if (r < 76) return make_reply(RK_ACK_SAME);
            if (r < 84) return make_reply(RK_BAD_SUM);
            if (r < 89) return make_reply(RK_ACK_OTHER);
            if (r < 92) return make_reply(RK_JUNK);
            if (r < 96) return plain_item(sawarq_pkg::CMD_SEND);
            return plain_item(sawarq_pkg::CMD_END);
        end
        if (r < 50) return plain_item(sawarq_pkg::CMD_TICK);
        if (r < 78) return make_reply(RK_END_OK);
        if (r < 86) return make_reply(RK_END_BAD_TAG);
        if (r < 93) return make_reply(RK_BAD_SUM);
        if (r < 97) return plain_item(sawarq_pkg::CMD_SEND);
        return plain_item(sawarq_pkg::CMD_END);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        // keep the log bounded on a badly broken block
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch %s at cycle %0d: got %0h, expected %0h",
                     what, cycle_count, got, want);
    endtask

    task automatic check_beat(input sawarq_pkg::result_t want);
        if (action !== want.action)
            report("action", 32'(action), 32'(want.action));
        if (tx_tag !== want.tx_tag)
            report("tx_tag", 32'(tx_tag), 32'(want.tx_tag));
        if (tx_seq !== want.tx_seq)
            report("tx_seq", 32'(tx_seq), 32'(want.tx_seq));
        if (tx_ack !== want.tx_ack)
            report("tx_ack", 32'(tx_ack), 32'(want.tx_ack));
        if (tx_window !== want.tx_window)
            report("tx_window", 32'(tx_window), 32'(want.tx_window));
        if (tx_length !== want.tx_length)
            report("tx_length", 32'(tx_length), 32'(want.tx_length));
        if (tx_checksum !== want.tx_checksum)
            report("tx_checksum", 32'(tx_checksum), 32'(want.tx_checksum));
        if (retry_number !== want.retry_number)
            report("retry_number", 32'(retry_number), 32'(want.retry_number));
    endtask

    task automatic drive_item(input item_t it);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= it.cmd;
        seg_length  <= it.len;
        reply_word0 <= it.w0;
        reply_word1 <= it.w1;
        reply_word2 <= it.w2;
        reply_word3 <= it.w3;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(arq_predict(it));
    endtask

    // input quiet and every result back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'h0, value})
            report("register readback", prdata, {16'h0, value});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] timeout, input logic [7:0] limit);
        settle();
        write_reg(sawarq_pkg::REG_INIT_TIMEOUT, timeout);
        write_reg(sawarq_pkg::REG_RETRY_LIMIT, {8'h0, limit});
        cfg_timeout = timeout;
        cfg_limit   = limit;
    endtask

    // each command and each reply outcome at least once, under the reset settings
    task automatic test_handshakes();
        item_t it;
        drive_item(plain_item(sawarq_pkg::CMD_TICK));
        it = make_reply(RK_JUNK);
        it.w0 = 16'hffff;
        it.w1 = 16'hffff;
        it.w2 = 16'hffff;
        it.w3 = 16'hffff;
        drive_item(it);
        it = plain_item(sawarq_pkg::CMD_SEND);
        it.len = 16'h0000;
        drive_item(it);
        drive_item(plain_item(sawarq_pkg::CMD_SEND));
        drive_item(plain_item(sawarq_pkg::CMD_END));
        drive_item(make_reply(RK_ACK_SAME));
        drive_item(make_reply(RK_BAD_SUM));
        drive_item(plain_item(sawarq_pkg::CMD_TICK));
        drive_item(make_reply(RK_ACK_NEXT));
        it = plain_item(sawarq_pkg::CMD_SEND);
        it.len = 16'hffff;
        drive_item(it);
        it = make_reply(RK_JUNK);
        it.w0 = 16'h0;
        it.w1 = 16'h0;
        it.w2 = 16'h0;
        it.w3 = 16'h0;
        drive_item(it);
        drive_item(make_reply(RK_ACK_OTHER));
        drive_item(plain_item(sawarq_pkg::CMD_END));
        drive_item(make_reply(RK_END_OK));
        drive_item(plain_item(sawarq_pkg::CMD_END));
        drive_item(make_reply(RK_END_BAD_TAG));
        drive_item(plain_item(sawarq_pkg::CMD_END));
        drive_item(make_reply(RK_BAD_SUM));
        drive_item(plain_item(sawarq_pkg::CMD_SEND));
        drive_item(make_reply(RK_ACK_NEXT));
        drive_item(plain_item(sawarq_pkg::CMD_END));
        drive_item(make_reply(RK_END_OK));
    endtask

    // data phase keeps counting across resends until the retries run out
    task automatic test_data_backoff();
        set_timing(16'd2, 8'd2);
        drive_item(plain_item(sawarq_pkg::CMD_SEND));
        repeat (9) drive_item(plain_item(sawarq_pkg::CMD_TICK));
        drive_item(plain_item(sawarq_pkg::CMD_TICK));
    endtask

    // end phase restarts its count, then zero timeout and zero retries
    task automatic test_end_timer();
        set_timing(16'd0, 8'd1);
        drive_item(plain_item(sawarq_pkg::CMD_END));
        repeat (2) drive_item(plain_item(sawarq_pkg::CMD_TICK));
        set_timing(16'd0, 8'd0);
        drive_item(plain_item(sawarq_pkg::CMD_SEND));
        drive_item(plain_item(sawarq_pkg::CMD_TICK));
    endtask

    // long clean transfer so the sequence byte wraps
    task automatic test_seq_wrap();
        set_timing(16'hffff, 8'hff);
        repeat (260)
        begin
            drive_item(plain_item(sawarq_pkg::CMD_SEND));
            if ($urandom_range(0, 3) == 0)
                drive_item(plain_item(sawarq_pkg::CMD_TICK));
            drive_item(make_reply(RK_ACK_NEXT));
        end
    endtask

    // receiver holds off while beats keep coming, so the input side stalls
    task automatic test_backpressure();
        set_timing(16'd3, 8'd3);
        idle_on  = 1'b0;
        hold_req = 80;
        repeat (30) drive_item(random_item());
        idle_on  = 1'b1;
    endtask

    task automatic test_random();
        logic [15:0] timeouts[6];
        logic [7:0]  limits[6];
        timeouts = '{16'd1, 16'd3, 16'd0, 16'hffff, 16'd7, 16'd4};
        limits   = '{8'd255, 8'd2, 8'd0, 8'd0, 8'd1, 8'd3};
        for (int k = 0; k < 6; k++)
        begin
            set_timing(timeouts[k], limits[k]);
            // last stretch runs at full rate
            if (k == 5)
                idle_on = 1'b0;
            repeat (110) drive_item(random_item());
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req != 0 && !hold_taken)
        begin
            hold_left  = hold_req;
            hold_taken = 1'b1;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected beat, action", {29'h0, action}, 32'h0);
            else
                check_beat(pending_results.pop_front());
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_handshakes();
        test_data_backoff();
        test_end_timer();
        test_seq_wrap();
        test_backpressure();
        test_random();
        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
sv/sawarq_pkg.sv
sv/stop_and_wait_arq_sender.sv
dv/tb.sv
